// ----- hdl/fha_pkg.sv -----
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
package fha_pkg;

  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int IDX_W            = 10;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_NULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_INSERT,
    OP_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCAN,
    FS_MNEXT,
    FS_MPREV
  } fsm_t;

endpackage

// ----- hdl/fha_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface fha_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [9:0] request_bytes;
  logic [9:0] release_offset;
  logic       release_null;
  modport source (output valid, kind, request_bytes, release_offset, release_null,
                  input ready);
  modport sink   (input valid, kind, request_bytes, release_offset, release_null,
                  output ready);
endinterface

interface fha_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] grant_offset;
  logic [9:0] grant_bytes;
  modport source (output valid, status, grant_offset, grant_bytes, input ready);
  modport sink   (input valid, status, grant_offset, grant_bytes, output ready);
endinterface

// ----- hdl/fha_cell.sv -----
// one segment entry of the table, shifts with its neighbors
`timescale 1ns / 1ps
module fha_cell import fha_pkg::*; #(
  parameter int K  = 0,
  parameter int AW = 11,
  parameter int RESET_SIZE = 992
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [AW-1:0] wb,
  input  logic [AW-1:0] ws,
  input  logic          wf,
  input  logic [AW-1:0] nb,
  input  logic [AW-1:0] ns,
  input  logic [AW-1:0] lb,
  input  logic [AW-1:0] ls,
  input  logic          lf,
  input  logic [AW-1:0] rb,
  input  logic [AW-1:0] rs,
  input  logic          rf,
  output logic [AW-1:0] b,
  output logic [AW-1:0] s,
  output logic          f
);
  int ci;
  assign ci = int'(cmd.idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
      s <= (K == 0) ? AW'(RESET_SIZE) : '0;
      f <= (K == 0);
    end else begin
      unique case (cmd.op)
        OP_WRITE: begin
          if (K == ci) begin
            b <= wb; s <= ws; f <= wf;
          end
        end
        OP_INSERT: begin
          if (K == ci) begin
            b <= wb; s <= ws; f <= wf;
          end else if (K == ci + 1) begin
            b <= nb; s <= ns; f <= 1'b1;
          end else if (K > ci + 1) begin
            b <= lb; s <= ls; f <= lf;
          end
        end
        OP_DROP: begin
          if (K == ci - 1) begin
            b <= wb; s <= ws; f <= wf;
          end else if (K >= ci) begin
            b <= rb; s <= rs; f <= rf;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/first_fit_heap_allocator.sv -----
// top level: segment chain and the scan/merge sequencer
// allocate scans the entries in order from entry 0 and answers at the first free one that fits
// free scans for its entry, then merges a free right and then a free left neighbor; null is not scanned
// one request at a time: the next is taken only after scan and merge end and the response is taken
// reset (synchronous, active high): one free segment covering the heap, no result pending
// the response register frees the next request the cycle after the result is taken
`timescale 1ns / 1ps
module first_fit_heap_allocator import fha_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input logic       clk,
  input logic       rst,
  fha_req_if.sink   req,
  fha_rsp_if.source rsp
);
  localparam int AW  = $clog2(HEAP_BYTES) + 1;
  localparam int CW  = ((AW > 10) ? AW : 10) + 2;
  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW  = $clog2(MAX_SEGMENTS + 1);

  // chain storage views
  logic [AW-1:0] cb [MAX_SEGMENTS];
  logic [AW-1:0] cs [MAX_SEGMENTS];
  logic          cf [MAX_SEGMENTS];

  cell_cmd_t     cmd;
  logic [AW-1:0] wb, ws, nb, ns;
  logic          wf;

  // sequencer registers
  fsm_t          state, state_next;
  logic [NW-1:0] idx, idx_next;
  logic [NW-1:0] count, count_next;
  logic          kind;
  logic [9:0]    req_bytes, rel_off;
  logic [AW-1:0] cur_base, cur_base_next, cur_size, cur_size_next;

  // response register
  logic          rvalid, rvalid_next;
  logic [1:0]    rstatus, rstatus_next;
  logic [9:0]    roff, roff_next, rbytes, rbytes_next;

  // single read port on the chain
  logic [NW-1:0] raddr;
  logic [AW-1:0] rd_b, rd_s;
  logic          rd_f;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      logic [AW-1:0] lb, ls, rb2, rs2;
      logic          lf, rf2;
      if (g == 0) begin : g_l0
        assign lb = '0; assign ls = '0; assign lf = 1'b0;
      end else begin : g_ln
        assign lb = cb[g-1]; assign ls = cs[g-1]; assign lf = cf[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_rl
        assign rb2 = '0; assign rs2 = '0; assign rf2 = 1'b0;
      end else begin : g_rn
        assign rb2 = cb[g+1]; assign rs2 = cs[g+1]; assign rf2 = cf[g+1];
      end
      fha_cell #(
        .K(g), .AW(AW), .RESET_SIZE(HEAP_BYTES - HEADER_BYTES)
      ) u_cell (
        .clk(clk), .rst(rst), .cmd(cmd),
        .wb(wb), .ws(ws), .wf(wf), .nb(nb), .ns(ns),
        .lb(lb), .ls(ls), .lf(lf), .rb(rb2), .rs(rs2), .rf(rf2),
        .b(cb[g]), .s(cs[g]), .f(cf[g])
      );
    end
  endgenerate

  assign rd_b = cb[raddr[IW-1:0]];
  assign rd_s = cs[raddr[IW-1:0]];
  assign rd_f = cf[raddr[IW-1:0]];

  assign req.ready    = (state == FS_IDLE) && !rvalid;
  assign rsp.valid    = rvalid;
  assign rsp.status   = rstatus;
  assign rsp.grant_offset = roff;
  assign rsp.grant_bytes  = rbytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FS_IDLE;
      count  <= NW'(1);
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rvalid <= rvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur_base <= cur_base_next;
    cur_size <= cur_size_next;
    rstatus  <= rstatus_next;
    roff     <= roff_next;
    rbytes   <= rbytes_next;
    if (req.valid && req.ready) begin
      kind      <= req.kind;
      req_bytes <= req.request_bytes;
      rel_off   <= req.release_offset;
    end
  end

  // wide copies for the size and offset arithmetic
  logic [CW-1:0] rb_w, rs_w, req_w, off_w, hdr_w, sum_w;
  assign rb_w  = CW'(rd_b);
  assign rs_w  = CW'(rd_s);
  assign req_w = CW'(req_bytes);
  assign off_w = CW'(rel_off);
  assign hdr_w = CW'(HEADER_BYTES);
  assign sum_w = rb_w + hdr_w;

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    count_next    = count;
    cur_base_next = cur_base;
    cur_size_next = cur_size;
    rvalid_next   = rvalid && !rsp.ready;
    rstatus_next  = rstatus;
    roff_next     = roff;
    rbytes_next   = rbytes;
    cmd.op        = OP_NOP;
    cmd.idx       = IDX_W'(idx);
    wb = rd_b; ws = rd_s; wf = rd_f;
    nb = '0; ns = '0;
    raddr = idx;

    unique case (state)
      FS_IDLE: begin
        if (req.valid && req.ready) begin
          idx_next = '0;
          if (req.kind && req.release_null) begin
            // null free: answer at once
            rvalid_next  = 1'b1;
            rstatus_next = ST_NULL;
            roff_next    = '0;
            rbytes_next  = '0;
          end else begin
            state_next = FS_SCAN;
          end
        end
      end

      FS_SCAN: begin
        if (idx >= count) begin
          // ran off the end of the table
          state_next   = FS_IDLE;
          rvalid_next  = 1'b1;
          rstatus_next = kind ? ST_BAD : ST_NOFIT;
          roff_next    = '0;
          rbytes_next  = '0;
        end else if (!kind) begin
          if (rd_f && rs_w >= req_w) begin
            state_next   = FS_IDLE;
            rvalid_next  = 1'b1;
            rstatus_next = ST_DONE;
            roff_next    = sum_w[9:0];
            wf           = 1'b0;
            // split only if more than one header remains past the new header and the table is not full
            if (rs_w > req_w + hdr_w + hdr_w && count < NW'(MAX_SEGMENTS)) begin
              cmd.op      = OP_INSERT;
              ws          = AW'(req_w);
              nb          = AW'(sum_w + req_w);
              ns          = AW'(rs_w - req_w - hdr_w);
              count_next  = count + NW'(1);
              rbytes_next = req_w[9:0];
            end else begin
              cmd.op      = OP_WRITE;
              rbytes_next = rs_w[9:0];
            end
          end else begin
            idx_next = idx + NW'(1);
          end
        end else begin
          if (sum_w == off_w && !rd_f) begin
            cmd.op        = OP_WRITE;
            wf            = 1'b1;
            cur_base_next = rd_b;
            cur_size_next = rd_s;
            state_next    = FS_MNEXT;
          end else begin
            idx_next = idx + NW'(1);
          end
        end
      end

      FS_MNEXT: begin
        // absorb a free right neighbor
        raddr      = idx + NW'(1);
        state_next = FS_MPREV;
        if (idx + NW'(1) < count && rd_f) begin
          cmd.op        = OP_DROP;
          cmd.idx       = IDX_W'(idx + NW'(1));
          wb            = cur_base;
          ws            = AW'(CW'(cur_size) + hdr_w + rs_w);
          wf            = 1'b1;
          cur_size_next = ws;
          count_next    = count - NW'(1);
        end
      end

      FS_MPREV: begin
        // fold into a free left neighbor
        raddr        = idx - NW'(1);
        state_next   = FS_IDLE;
        rvalid_next  = 1'b1;
        rstatus_next = ST_DONE;
        roff_next    = '0;
        rbytes_next  = '0;
        if (idx != '0 && rd_f) begin
          cmd.op     = OP_DROP;
          cmd.idx    = IDX_W'(idx);
          wb         = rd_b;
          ws         = AW'(rs_w + hdr_w + CW'(cur_size));
          wf         = 1'b1;
          count_next = count - NW'(1);
        end
      end

      default: state_next = FS_IDLE;
    endcase
  end
endmodule

// ----- test/tb.sv -----
// self-checking testbench for the first-fit heap allocator
`timescale 1ns / 1ps
class heap_scoreboard;
  typedef struct {
    int unsigned base;
    int unsigned size;
    bit          is_free;
  } seg_t;

  typedef struct {
    logic [1:0] status;
    logic [9:0] grant_offset;
    logic [9:0] grant_bytes;
  } grant_t;

  seg_t        segs[32];
  int unsigned seg_count;
  grant_t      pending[$];
  int          errors;
  int          checked;

  function new();
    errors = 0;
    checked = 0;
    clear_heap();
  endfunction

  function void clear_heap();
    foreach (segs[j]) segs[j] = '{0, 0, 0};
    segs[0] = '{0, 1024 - 32, 1};
    seg_count = 1;
  endfunction

  // fold entry idx+1 into entry idx and close the gap
  function void merge_next(int unsigned idx);
    int unsigned k;
    if (idx + 1 >= seg_count) return;
    segs[idx].size += 32 + segs[idx + 1].size;
    for (k = idx + 1; k + 1 < seg_count; k++) segs[k] = segs[k + 1];
    seg_count--;
    segs[seg_count] = '{0, 0, 0};
  endfunction

  // predict the response of one accepted request
  function void note_request(logic kind, logic [9:0] req_bytes, logic [9:0] offset,
                             logic is_null);
    grant_t      g;
    int unsigned i;
    int unsigned k;
    int unsigned req;
    g = '{fha_pkg::ST_NOFIT, 10'd0, 10'd0};
    req = req_bytes;
    if (kind == 1'b0) begin
      for (i = 0; i < seg_count; i++) begin
        if (!segs[i].is_free || segs[i].size < req) continue;
        if (segs[i].size >= req + 32 && segs[i].size - req - 32 > 32 && seg_count < 32) begin
          for (k = seg_count; k > i + 1; k--) segs[k] = segs[k - 1];
          segs[i + 1] = '{segs[i].base + 32 + req, segs[i].size - req - 32, 1};
          seg_count++;
          segs[i].size = req;
        end
        segs[i].is_free = 0;
        g = '{fha_pkg::ST_DONE, 10'(segs[i].base + 32), 10'(segs[i].size)};
        break;
      end
    end else if (is_null) begin
      g.status = fha_pkg::ST_NULL;
    end else begin
      g.status = fha_pkg::ST_BAD;
      for (i = 0; i < seg_count; i++) begin
        if (segs[i].base + 32 == offset && !segs[i].is_free) begin
          segs[i].is_free = 1;
          if (i + 1 < seg_count && segs[i + 1].is_free) merge_next(i);
          if (i > 0 && segs[i - 1].is_free) merge_next(i - 1);
          g.status = fha_pkg::ST_DONE;
          break;
        end
      end
    end
    pending.push_back(g);
  endfunction

  function void check_grant(logic [1:0] st, logic [9:0] ofs, logic [9:0] sz);
    grant_t g;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: response with none expected, got %0d/%0d/%0d", $time, st, ofs, sz);
      errors++;
      return;
    end
    g = pending.pop_front();
    if (st !== g.status) begin
      $display("%0t: status expected %0d actual %0d", $time, g.status, st);
      errors++;
    end
    if (ofs !== g.grant_offset) begin
      $display("%0t: grant_offset expected %0d actual %0d", $time, g.grant_offset, ofs);
      errors++;
    end
    if (sz !== g.grant_bytes) begin
      $display("%0t: grant_bytes expected %0d actual %0d", $time, g.grant_bytes, sz);
      errors++;
    end
  endfunction

  // offset of a random allocated segment, or 0 when there is none
  function logic [9:0] pick_live();
    int unsigned live[$];
    foreach (segs[j]) if (j < seg_count && !segs[j].is_free) live.push_back(segs[j].base + 32);
    if (live.size() == 0) return 10'd0;
    return 10'(live[$urandom_range(live.size() - 1)]);
  endfunction
endclass

module tb;
  import fha_pkg::*;

  logic clk;
  logic rst;
  int   cycle;
  int   send_idle;   // idle chance in percent for the sender
  int   recv_idle;   // same for the receiver
  bit   hold_off;    // long receiver stall in progress
  int   sent;

  fha_req_if req ();
  fha_rsp_if rsp ();

  heap_scoreboard sb;

  first_fit_heap_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on total cycles
  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    rsp.ready = 0;
    forever begin
      @(posedge clk);
      if (rst || hold_off) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // score responses at the edge they are taken
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_grant(rsp.status, rsp.grant_offset, rsp.grant_bytes);
  end

  // offer one request and wait until it is taken
  task automatic send_request(logic kind, logic [9:0] nbytes, logic [9:0] offset,
                              logic is_null);
    do @(posedge clk); while (send_idle > 0 && $urandom_range(99) < send_idle);
    req.valid          <= 1;
    req.kind           <= kind;
    req.request_bytes  <= nbytes;
    req.release_offset <= offset;
    req.release_null   <= is_null;
    do @(posedge clk); while (!req.ready);
    sb.note_request(kind, nbytes, offset, is_null);
    sent++;
    req.valid <= 0;
  endtask

  task automatic alloc(logic [9:0] nbytes);
    send_request(1'b0, nbytes, 10'($urandom), 1'($urandom));
  endtask

  task automatic release_at(logic [9:0] offset);
    send_request(1'b1, 10'($urandom), offset, 1'b0);
  endtask

  // a random request, weighted toward well-formed alloc/free traffic
  task automatic random_request();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) alloc(10'($urandom_range(sel < 30 ? 64 : 1023)));
    else if (sel < 80) release_at(sb.pick_live());
    else if (sel < 88) release_at(10'($urandom));
    else if (sel < 94) send_request(1'b1, 10'($urandom), 10'($urandom), 1'b1);
    else alloc(10'($urandom_range(31)));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sent = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_off = 0;
    req.valid = 0;
    req.kind = 0;
    req.request_bytes = 0;
    req.release_offset = 0;
    req.release_null = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: whole heap, no fit, bad and double free, null, exact fit, zero bytes
    alloc(10'd992);
    alloc(10'd0);
    release_at(10'd32);
    release_at(10'd32);
    release_at(10'd0);
    send_request(1'b1, 10'h3ff, 10'h3ff, 1'b1);
    alloc(10'd1023);
    alloc(10'd0);
    alloc(10'd900);
    alloc(10'd60);
    alloc(10'd100);
    release_at(10'd32);
    release_at(10'd64);
    alloc(10'd0);
    release_at(10'd32);
    // fill the table with small segments, then free two random live segments and offset 33
    repeat (33) alloc(10'd1);
    release_at(sb.pick_live());
    release_at(sb.pick_live());
    release_at(10'd33);
    drain();

    // long receiver stall while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (6) random_request();
    join

    send_idle = 8;  recv_idle = 50;
    repeat (310) random_request();
    send_idle = 50; recv_idle = 8;
    repeat (310) random_request();
    send_idle = 0;  recv_idle = 0;
    repeat (310) random_request();
    drain();

    $display("ran %0d requests (alloc, free, null, bad free), %0d responses checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- first_fit_heap_allocator.f -----
hdl/fha_pkg.sv
hdl/fha_if.sv
hdl/fha_cell.sv
hdl/first_fit_heap_allocator.sv
test/tb.sv
